### rtl/bhq_pkg.sv
// ----------------------------------------------------------------------------
// bhq_pkg
// Shared types, codes and the ordering function of the binary min-heap queue.
// ----------------------------------------------------------------------------
package bhq_pkg;

  localparam int SCORE_W = 10;
  localparam int DEPTH_W = 10;
  localparam int DIR_W   = 2;
  localparam int TAG_W   = 16;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 9;

  // Request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // One heap entry, packed as score, depth, dir, tag from the top down
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0] depth;
    logic [DIR_W-1:0]   dir;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // One result as handed from the controller to the output stage
  typedef struct packed {
    entry_t             entry;
    logic [STAT_W-1:0]  status;
    logic [FILL_W-1:0]  fill;
  } res_t;

  // Strict ordering on score, then depth, then dir; tag takes no part
  function automatic logic key_less(entry_t a, entry_t b);
    return {a.score, a.depth, a.dir} < {b.score, b.depth, b.dir};
  endfunction

endpackage

### rtl/bhq_if.sv
// ----------------------------------------------------------------------------
// bhq_if
// Request and response channels of the heap queue, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bhq_req_if import bhq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [SCORE_W-1:0] key_score;
  logic [DEPTH_W-1:0] key_depth;
  logic [DIR_W-1:0]   key_dir;
  logic [TAG_W-1:0]   entry_tag;

  modport source (output valid, req_type, key_score, key_depth, key_dir, entry_tag,
                  input ready);
  modport sink   (input valid, req_type, key_score, key_depth, key_dir, entry_tag,
                  output ready);
endinterface

interface bhq_rsp_if import bhq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] out_score;
  logic [DEPTH_W-1:0] out_depth;
  logic [DIR_W-1:0]   out_dir;
  logic [TAG_W-1:0]   out_tag;
  logic [STAT_W-1:0]  status;
  logic [FILL_W-1:0]  fill_count;

  modport source (output valid, out_score, out_depth, out_dir, out_tag, status, fill_count,
                  input ready);
  modport sink   (input valid, out_score, out_depth, out_dir, out_tag, status, fill_count,
                  output ready);
endinterface

### rtl/bhq_ram.sv
// ----------------------------------------------------------------------------
// bhq_ram
// Heap storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bhq_ram import bhq_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] ra_addr,
  input  logic [AW-1:0] rb_addr,
  output entry_t        ra_data,
  output entry_t        rb_data
);

  entry_t mem [DEPTH];
  entry_t ra_data_r;
  entry_t rb_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data_r <= mem[ra_addr];
    rb_data_r <= mem[rb_addr];
  end

  assign ra_data = ra_data_r;
  assign rb_data = rb_data_r;

endmodule

### rtl/bhq_ctrl.sv
// ----------------------------------------------------------------------------
// bhq_ctrl
// Sequencer for push (sift up) and pop (sift down) over the heap memory.
// ----------------------------------------------------------------------------
module bhq_ctrl import bhq_pkg::*; #(
  parameter int CAPACITY = 256,
  parameter int AW       = 8,
  parameter int CW       = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_type,
  input  entry_t        in_entry,
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output entry_t        mem_wdata,
  output logic [AW-1:0] mem_ra_addr,
  output logic [AW-1:0] mem_rb_addr,
  input  entry_t        mem_ra_data,
  input  entry_t        mem_rb_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_POP   = 6'b000010,
    S_UP    = 6'b000100,
    S_DN    = 6'b001000,
    S_PLACE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  entry_t            entry_r, entry_nxt;
  entry_t            got_r, got_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  logic [CW:0]       kid_w;
  logic [CW:0]       kid_nxt_w;
  logic              right_ok;
  logic              left_less;
  logic              right_less;
  entry_t            cur_best;
  logic [CW+8:0]     fill_ext;

  function automatic logic [AW-1:0] parent_of(logic [AW-1:0] p);
    logic [AW-1:0] pm1;
    pm1 = p - AW'(1);
    return pm1 >> 1;
  endfunction

  function automatic logic [CW:0] kid_of(logic [AW-1:0] p);
    return (CW+1)'({p, 1'b1});
  endfunction

  assign in_ready = (state_r == S_IDLE);

  // Children of the current hole, from the registered memory read
  assign kid_w      = kid_of(pos_r);
  assign right_ok   = (kid_w + (CW+1)'(1)) < {1'b0, count_r};
  assign left_less  = key_less(mem_ra_data, entry_r);
  assign cur_best   = left_less ? mem_ra_data : entry_r;
  assign right_less = right_ok && key_less(mem_rb_data, cur_best);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    entry_nxt  = entry_r;
    got_nxt    = got_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = pos_r;
    mem_wdata  = entry_r;
    res_valid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          got_nxt    = '0;
          status_nxt = STAT_OK;
          if (in_type == REQ_PUSH) begin
            if (count_r >= CW'(CAPACITY)) begin
              status_nxt = STAT_FULL;
              state_nxt  = S_DONE;
            end else begin
              entry_nxt = in_entry;
              pos_nxt   = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              state_nxt = (count_r == '0) ? S_PLACE : S_UP;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = STAT_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              count_nxt = count_r - CW'(1);
              state_nxt = S_POP;
            end
          end
        end
      end
      S_POP: begin
        // root and last entry arrive together
        got_nxt   = mem_ra_data;
        entry_nxt = mem_rb_data;
        pos_nxt   = '0;
        if (count_r == '0) begin
          state_nxt = S_DONE;
        end else if (kid_of('0) >= {1'b0, count_r}) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_DN;
        end
      end
      S_UP: begin
        mem_we = 1'b1;
        if (key_less(entry_r, mem_ra_data)) begin
          // move the parent down into the hole
          mem_wdata = mem_ra_data;
          pos_nxt   = parent_of(pos_r);
          state_nxt = (parent_of(pos_r) == '0) ? S_PLACE : S_UP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DN: begin
        mem_we = 1'b1;
        if (right_less || left_less) begin
          // move the smaller child up into the hole
          mem_wdata = right_less ? mem_rb_data : mem_ra_data;
          pos_nxt   = right_less ? AW'(kid_w + (CW+1)'(1)) : kid_w[AW-1:0];
          state_nxt = (kid_of(pos_nxt) >= {1'b0, count_r}) ? S_PLACE : S_DN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Read addresses follow the next hole position; reads never hit the
  // entry written in the same cycle, so no forwarding is needed.
  assign kid_nxt_w = kid_of(pos_nxt);

  always_comb begin
    mem_ra_addr = parent_of(pos_nxt);
    mem_rb_addr = count_nxt[AW-1:0];
    case (state_nxt)
      S_POP: begin
        mem_ra_addr = '0;
        mem_rb_addr = count_nxt[AW-1:0];
      end
      S_DN: begin
        mem_ra_addr = kid_nxt_w[AW-1:0];
        mem_rb_addr = kid_nxt_w[AW-1:0] + AW'(1);
      end
      default: begin
        mem_ra_addr = parent_of(pos_nxt);
        mem_rb_addr = count_nxt[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    entry_r  <= entry_nxt;
    got_r    <= got_nxt;
    status_r <= status_nxt;
  end

  assign fill_ext   = (CW+9)'(count_r);
  assign res.entry  = got_r;
  assign res.status = status_r;
  assign res.fill   = fill_ext[8:0];

endmodule

### rtl/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Min-heap priority queue in an on-chip memory with a registered result.
// ----------------------------------------------------------------------------
//   channel   dir  payload                                              
//   in_req    in   req_type, key_score, key_depth, key_dir, entry_tag
//   out_rsp   out  out_score, out_depth, out_dir, out_tag, status, fill_count
//
// One request is in flight at a time. A push sifts up through the levels it
// climbs; a pop reads the root and the last entry together, then sinks the
// last entry from the root unless the heap is now empty. The sift moves a
// hole through the two-read memory. Refused pushes and empty pops go straight
// to the result.
// Reset clears the state, the entry count and the output valid; the memory needs no clearing.
// A held result does not block the next request until that one completes.
// ----------------------------------------------------------------------------
module binary_min_heap_queue import bhq_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  bhq_req_if.sink    in_req,
  bhq_rsp_if.source  out_rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [FILL_W-1:0] CAP_FILL = FILL_W'(CAPACITY);

  entry_t        in_entry;
  logic          in_ready;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_ra_addr;
  logic [AW-1:0] mem_rb_addr;
  entry_t        mem_ra_data;
  entry_t        mem_rb_data;

  logic          out_valid_r;
  res_t          out_data_r;

  assign in_entry.score = in_req.key_score;
  assign in_entry.depth = in_req.key_depth;
  assign in_entry.dir   = in_req.key_dir;
  assign in_entry.tag   = in_req.entry_tag;
  assign in_req.ready   = in_ready;

  bhq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_ready    (in_ready),
    .in_type     (in_req.req_type),
    .in_entry    (in_entry),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_ra_addr (mem_ra_addr),
    .mem_rb_addr (mem_rb_addr),
    .mem_ra_data (mem_ra_data),
    .mem_rb_data (mem_rb_data)
  );

  bhq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .ra_addr (mem_ra_addr),
    .rb_addr (mem_rb_addr),
    .ra_data (mem_ra_data),
    .rb_data (mem_rb_data)
  );

  // Output stage: load when empty or when the held result transfers
  assign res_ready = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.out_score  = out_data_r.entry.score;
  assign out_rsp.out_depth  = out_data_r.entry.depth;
  assign out_rsp.out_dir    = out_data_r.entry.dir;
  assign out_rsp.out_tag    = out_data_r.entry.tag;
  assign out_rsp.status     = out_data_r.status;
  assign out_rsp.fill_count = out_data_r.fill;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request accepted while another is in flight");

  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.status == STAT_FULL |-> out_rsp.fill_count == CAP_FILL)
    else $error("refused push without a full heap");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.status == STAT_EMPTY |->
      out_rsp.fill_count == '0 && out_rsp.out_tag == '0 && out_rsp.out_score == '0)
    else $error("empty pop with nonzero fields");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_valid_r)
    else $error("result lost at output stage");

endmodule
